### design/worker_wake_coordinator_defines.svh
// ----------------------------------------------------------------------------
// Worker wake coordinator assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WORKER_WAKE_COORDINATOR_DEFINES_SVH
`define WORKER_WAKE_COORDINATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wwc_pkg.sv
// ----------------------------------------------------------------------------
// Worker wake coordinator package
// Widths, action codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package wwc_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int WID_W       = $clog2(MAX_WORKERS);
    localparam int HGT_W       = $clog2(MAX_WORKERS + 1);
    localparam int SPIN_W      = 6;
    localparam int WCNT_W      = 7;
    localparam int ACT_W       = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [0:0] REG_WORKER_COUNT = 1'b0;
    localparam logic [WCNT_W-1:0] WORKER_COUNT_RST = WCNT_W'(64);

    typedef enum logic [ACT_W-1:0] {
        ACT_START_SPIN    = 3'd0,
        ACT_STOP_SPIN     = 3'd1,
        ACT_STEP_DOWN     = 3'd2,
        ACT_BECOME_ACTIVE = 3'd3,
        ACT_NEW_TASK      = 3'd4,
        ACT_REQ_STOP      = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_EV,
        ST_SRCH_FIN,
        ST_POP_RD,
        ST_POP_EV
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic simple_op;
        logic srch_start;
        logic srch_step;
        logic srch_finish;
        logic pop_sel;
        logic pop_emit;
        logic set_stop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    out_free;
        logic    listed_hit;
        logic    height_zero;
        logic    spin_zero;
        logic    srch_last;
        logic    pop_last;
    } status_t;

endpackage

### design/wwc_ram.sv
// ----------------------------------------------------------------------------
// Worker wake coordinator RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/wwc_ctrl.sv
// ----------------------------------------------------------------------------
// Worker wake coordinator controller
// Sequences item decode, idle stack search and compaction, and stack pops.
// ----------------------------------------------------------------------------
module wwc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wwc_pkg::status_t  stat,
    output wwc_pkg::cmd_t     cmd
);

    import wwc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.act == ACT_BECOME_ACTIVE && stat.listed_hit)
                begin
                    state_next = ST_SRCH_RD;
                end
                else if (stat.act == ACT_NEW_TASK && !stat.height_zero && stat.spin_zero)
                begin
                    state_next = ST_POP_RD;
                end
                else if (stat.act == ACT_REQ_STOP && !stat.height_zero)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    if (stat.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_EV;
            end
            ST_SRCH_EV:
            begin
                state_next = stat.srch_last ? ST_SRCH_FIN : ST_SRCH_RD;
            end
            ST_SRCH_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_EV;
            end
            ST_POP_EV:
            begin
                if (stat.out_free)
                begin
                    state_next = (stat.act == ACT_REQ_STOP && !stat.pop_last) ?
                                 ST_POP_RD : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_DECODE:
            begin
                priority if (stat.act == ACT_BECOME_ACTIVE && stat.listed_hit)
                begin
                    cmd.srch_start = 1'b1;
                end
                else if (stat.act == ACT_NEW_TASK && !stat.height_zero && stat.spin_zero)
                begin
                    cmd.pop_sel = 1'b1;
                end
                else if (stat.act == ACT_REQ_STOP && !stat.height_zero)
                begin
                    cmd.pop_sel  = 1'b1;
                    cmd.set_stop = 1'b1;
                end
                else
                begin
                    cmd.simple_op = stat.out_free;
                end
            end
            ST_SRCH_RD:
            begin
                cmd.pop_sel = 1'b0;
            end
            ST_SRCH_EV:
            begin
                cmd.srch_step = 1'b1;
            end
            ST_SRCH_FIN:
            begin
                cmd.srch_finish = stat.out_free;
            end
            ST_POP_RD:
            begin
                cmd.pop_sel = 1'b1;
            end
            ST_POP_EV:
            begin
                cmd.pop_sel  = 1'b1;
                cmd.pop_emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/wwc_dp.sv
// ----------------------------------------------------------------------------
// Worker wake coordinator datapath
// Spin count, idle stack height, membership flags, stop flag and result beat.
// ----------------------------------------------------------------------------
module wwc_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wwc_pkg::cmd_t                cmd,
    output wwc_pkg::status_t             stat,
    input  logic [wwc_pkg::ACT_W-1:0]    action,
    input  logic [wwc_pkg::WID_W-1:0]    worker_id,
    input  logic [wwc_pkg::WCNT_W-1:0]   worker_count,
    output logic                         ram_we,
    output logic [wwc_pkg::WID_W-1:0]    ram_waddr,
    output logic [wwc_pkg::WID_W-1:0]    ram_wdata,
    output logic [wwc_pkg::WID_W-1:0]    ram_raddr,
    input  logic [wwc_pkg::WID_W-1:0]    ram_rdata,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         spin_granted,
    output logic                         last_spinner,
    output logic                         woken_valid,
    output logic [wwc_pkg::WID_W-1:0]    woken_worker,
    output logic                         stop_flag,
    output logic [wwc_pkg::SPIN_W-1:0]   spinning_count,
    output logic [wwc_pkg::HGT_W-1:0]    idle_count,
    output logic                         last
);

    import wwc_pkg::*;

    action_t             act_reg;
    logic [WID_W-1:0]    wid_reg;
    logic [SPIN_W-1:0]   spin_reg;
    logic [SPIN_W-1:0]   spin_next;
    logic [HGT_W-1:0]    height_reg;
    logic [HGT_W-1:0]    height_next;
    logic                stop_reg;
    logic                stop_next;
    logic [MAX_WORKERS-1:0] listed_reg;
    logic [MAX_WORKERS-1:0] listed_next;
    logic [WID_W-1:0]    idx_reg;
    logic                found_reg;
    logic                out_valid_reg;

    logic [SPIN_W:0]     spin_inc;
    logic [SPIN_W+1:0]   spin_need;
    logic                grant_ok;
    logic                push;
    logic                emit;
    logic [HGT_W-1:0]    height_dec;

    assign spin_inc   = {1'b0, spin_reg} + (SPIN_W+1)'(1);
    assign spin_need  = {spin_inc, 1'b0};
    assign grant_ok   = (spin_need <= (SPIN_W+2)'(worker_count)) &&
                        (spin_reg != {SPIN_W{1'b1}});
    assign height_dec = height_reg - HGT_W'(1);
    assign push       = cmd.simple_op && act_reg == ACT_STEP_DOWN &&
                        !listed_reg[wid_reg] && height_reg < HGT_W'(MAX_WORKERS);
    assign emit       = cmd.simple_op || cmd.srch_finish || cmd.pop_emit;

    // Stack memory access: pushes write at the top, compaction moves the entry
    // just read one place down.
    assign ram_we    = push || (cmd.srch_step && found_reg);
    assign ram_waddr = push ? height_reg[WID_W-1:0] : idx_reg - WID_W'(1);
    assign ram_wdata = push ? wid_reg : ram_rdata;
    assign ram_raddr = cmd.pop_sel ? height_dec[WID_W-1:0] : idx_reg;

    always_comb
    begin
        spin_next = spin_reg;
        if (cmd.simple_op && act_reg == ACT_START_SPIN && grant_ok)
        begin
            spin_next = spin_reg + SPIN_W'(1);
        end
        else if (cmd.simple_op && act_reg == ACT_STOP_SPIN && spin_reg != '0)
        begin
            spin_next = spin_reg - SPIN_W'(1);
        end
    end

    always_comb
    begin
        height_next = height_reg;
        if (push)
        begin
            height_next = height_reg + HGT_W'(1);
        end
        else if (cmd.srch_finish || cmd.pop_emit)
        begin
            height_next = height_dec;
        end
    end

    assign stop_next = stop_reg || cmd.set_stop ||
                       (cmd.simple_op && act_reg == ACT_REQ_STOP);

    always_comb
    begin
        listed_next = listed_reg;
        if (push)
        begin
            listed_next[wid_reg] = 1'b1;
        end
        if (cmd.srch_finish)
        begin
            listed_next[wid_reg] = 1'b0;
        end
        if (cmd.pop_emit)
        begin
            listed_next[ram_rdata] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg      <= '0;
            height_reg    <= '0;
            stop_reg      <= 1'b0;
            listed_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spin_reg   <= spin_next;
            height_reg <= height_next;
            stop_reg   <= stop_next;
            listed_reg <= listed_next;
            if (cmd.srch_start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.srch_step && ram_rdata == wid_reg)
            begin
                found_reg <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg <= action_t'(action);
            wid_reg <= worker_id;
        end
        if (cmd.srch_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.srch_step)
        begin
            idx_reg <= idx_reg + WID_W'(1);
        end
        if (emit)
        begin
            spin_granted   <= cmd.simple_op && act_reg == ACT_START_SPIN && grant_ok;
            last_spinner   <= cmd.simple_op && act_reg == ACT_STOP_SPIN &&
                              spin_reg == SPIN_W'(1);
            woken_valid    <= cmd.pop_emit;
            woken_worker   <= cmd.pop_emit ? ram_rdata : '0;
            stop_flag      <= stop_next;
            spinning_count <= spin_next;
            idle_count     <= height_next;
            last           <= cmd.pop_emit ?
                              (act_reg == ACT_NEW_TASK || height_dec == '0) : 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    assign stat.act         = act_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.listed_hit  = listed_reg[wid_reg];
    assign stat.height_zero = height_reg == '0;
    assign stat.spin_zero   = spin_reg == '0;
    assign stat.srch_last   = {1'b0, idx_reg} == height_dec;
    assign stat.pop_last    = height_reg == HGT_W'(1);

endmodule

### design/worker_wake_coordinator.sv
// ----------------------------------------------------------------------------
// Worker wake coordinator: tracks spinning workers, an idle stack and a stop flag.
// A plain action decodes and registers its result beat; a wake reads the stack top first.
// Become active walks the stack, reading and then checking one entry at a time.
// Request stop pops one worker per beat, each read through the one stack RAM read port.
// Reset (rst_n, async low) clears counts, flags and stack height; no clearing pass.
// ----------------------------------------------------------------------------
`include "worker_wake_coordinator_defines.svh"

module worker_wake_coordinator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input item channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wwc_pkg::ACT_W-1:0]     action,
    input  logic [wwc_pkg::WID_W-1:0]     worker_id,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          spin_granted,
    output logic                          last_spinner,
    output logic                          woken_valid,
    output logic [wwc_pkg::WID_W-1:0]     woken_worker,
    output logic                          stop_flag,
    output logic [wwc_pkg::SPIN_W-1:0]    spinning_count,
    output logic [wwc_pkg::HGT_W-1:0]     idle_count,
    output logic                          last,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wwc_pkg::APB_AW-1:0]    paddr,
    input  logic [wwc_pkg::APB_DW-1:0]    pwdata,
    output logic [wwc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import wwc_pkg::*;

    // The only register is worker_count at byte address 0. Bit 2 of the
    // address selects the register word; anything above it reads as zero
    // and ignores writes.
    logic [WCNT_W-1:0] worker_count_reg;
    logic              apb_wr;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= WORKER_COUNT_RST;
        end
        else if (apb_wr && paddr[APB_AW-1] == REG_WORKER_COUNT)
        begin
            worker_count_reg <= pwdata[WCNT_W-1:0];
        end
    end

    assign prdata = (paddr[APB_AW-1] == REG_WORKER_COUNT) ?
                    APB_DW'(worker_count_reg) : '0;

    // The controller only steps through states; the counts, flags and
    // the registered result beat live in the datapath. The output register
    // lets the block take the next item while a result beat still waits.
    cmd_t              cmd;
    status_t           stat;
    logic              ram_we;
    logic [WID_W-1:0]  ram_waddr;
    logic [WID_W-1:0]  ram_wdata;
    logic [WID_W-1:0]  ram_raddr;
    logic [WID_W-1:0]  ram_rdata;

    wwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wwc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .worker_id      (worker_id),
        .worker_count   (worker_count_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .spin_granted   (spin_granted),
        .last_spinner   (last_spinner),
        .woken_valid    (woken_valid),
        .woken_worker   (woken_worker),
        .stop_flag      (stop_flag),
        .spinning_count (spinning_count),
        .idle_count     (idle_count),
        .last           (last)
    );

    // Idle stack: worker numbers in push order, oldest at address zero.
    // Entries at or above the stack height are never used, so the memory
    // needs no reset.
    wwc_ram #(
        .WIDTH (WID_W),
        .DEPTH (MAX_WORKERS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One item at a time: after an accepted beat the input side closes.
    `WWC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input accepted while busy")
    // The stack never holds more workers than exist.
    `WWC_ASSERT_NOW(a_idle_bound, out_valid, idle_count <= HGT_W'(MAX_WORKERS),
                    "idle count above worker limit")
    // A wake beat carries no spin outcome.
    `WWC_ASSERT_NOW(a_wake_excl, out_valid && woken_valid, !spin_granted && !last_spinner,
                    "wake beat mixed with spin result")
    // Every wake beat that is not the last of its item reports the stop flag.
    `WWC_ASSERT_NOW(a_wake_stop, out_valid && woken_valid && !last, stop_flag,
                    "multi-beat wake without stop flag")

endmodule

### test/tb_worker_wake_coordinator.sv
// ----------------------------------------------------------------------------
// Worker wake coordinator testbench
// Drives scheduling events into the coordinator with random stalls on both
// channels. A local scoreboard follows the spin count, the idle stack and the
// stop flag, and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_worker_wake_coordinator;

    import wwc_pkg::*;

    // Cycles with no accepted beat of any kind before the run is declared hung.
    localparam int STALL_LIMIT  = 3000;
    // Cycles to let pass after the last expected beat before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Cycles to wait at the end, enough for a full stack walk.
    localparam int TAIL_CYCLES  = 150;

    localparam logic [APB_AW-1:0] WCNT_ADDR = APB_AW'(4 * REG_WORKER_COUNT);
    // Action codes that the block must treat as no-ops with a status beat.
    localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [WID_W-1:0] wid;
    } sched_beat_t;

    typedef struct packed {
        logic              granted;
        logic              last_spin;
        logic              wvalid;
        logic [WID_W-1:0]  wworker;
        logic              stop;
        logic [SPIN_W-1:0] spin;
        logic [HGT_W-1:0]  idle;
        logic              last;
    } outcome_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [ACT_W-1:0]  action         = '0;
    logic [WID_W-1:0]  worker_id      = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic              spin_granted;
    logic              last_spinner;
    logic              woken_valid;
    logic [WID_W-1:0]  woken_worker;
    logic              stop_flag;
    logic [SPIN_W-1:0] spinning_count;
    logic [HGT_W-1:0]  idle_count;
    logic              last;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [APB_AW-1:0] paddr          = '0;
    logic [APB_DW-1:0] pwdata         = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    worker_wake_coordinator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .worker_id      (worker_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .spin_granted   (spin_granted),
        .last_spinner   (last_spinner),
        .woken_valid    (woken_valid),
        .woken_worker   (woken_worker),
        .stop_flag      (stop_flag),
        .spinning_count (spinning_count),
        .idle_count     (idle_count),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 clk = ~clk;

    // Events waiting to be driven, and outcome beats the block still owes us.
    sched_beat_t beat_q[$];
    outcome_t    outcome_due_q[$];

    // Shadow copy of the coordinator: configuration and scheduler state.
    int               wcnt_shadow;
    int               spin_cnt;
    int               idle_hgt;
    logic [WID_W-1:0] idle_stk[MAX_WORKERS];
    logic             listed[MAX_WORKERS];
    logic             stop_seen;

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          idle_enable    = 1'b1;
    bit          in_taken       = 1'b0;
    int          in_gap         = 0;
    int          out_stall      = 0;
    sched_beat_t next_beat;
    outcome_t    got;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Builds one outcome beat; the status fields reflect the state as it
    // stands after the update that this beat reports.
    function automatic outcome_t make_outcome(logic granted, logic last_spin, logic wvalid,
                                              logic [WID_W-1:0] w, logic is_last);
        outcome_t o;
        o.granted   = granted;
        o.last_spin = last_spin;
        o.wvalid    = wvalid;
        o.wworker   = wvalid ? w : '0;
        o.stop      = stop_seen;
        o.spin      = SPIN_W'(spin_cnt);
        o.idle      = HGT_W'(idle_hgt);
        o.last      = is_last;
        return o;
    endfunction

    // Appends one owed outcome beat at the tail of the scoreboard.
    task automatic owe_outcome(input outcome_t o);
        outcome_due_q = {outcome_due_q, o};
    endtask

    // Applies one scheduling event to the shadow state and queues the
    // outcome beats it causes.
    task automatic apply_sched_event(input logic [ACT_W-1:0] act, input logic [WID_W-1:0] wid);
        int               pos;
        int               n;
        logic             was_one;
        logic [WID_W-1:0] w;
        case (act)
            ACT_START_SPIN:
            begin
                // The spin limit keeps at most half of the workers searching.
                if ((spin_cnt + 1) * 2 <= wcnt_shadow && spin_cnt < 63)
                begin
                    spin_cnt++;
                    owe_outcome(make_outcome(1'b1, 1'b0, 1'b0, '0, 1'b1));
                end
                else
                begin
                    owe_outcome(make_outcome(1'b0, 1'b0, 1'b0, '0, 1'b1));
                end
            end
            ACT_STOP_SPIN:
            begin
                // Saturates at zero; only the one-to-zero step is the last spinner.
                was_one = (spin_cnt == 1);
                if (spin_cnt > 0)
                    spin_cnt--;
                owe_outcome(make_outcome(1'b0, was_one, 1'b0, '0, 1'b1));
            end
            ACT_STEP_DOWN:
            begin
                if (!listed[wid] && idle_hgt < MAX_WORKERS)
                begin
                    idle_stk[idle_hgt] = wid;
                    idle_hgt++;
                    listed[wid] = 1'b1;
                end
                owe_outcome(make_outcome(1'b0, 1'b0, 1'b0, '0, 1'b1));
            end
            ACT_BECOME_ACTIVE:
            begin
                // Remove the worker from the stack and close the gap above it.
                if (listed[wid])
                begin
                    pos = idle_hgt;
                    for (int i = 0; i < idle_hgt; i++)
                    begin
                        if (idle_stk[i] == wid && pos == idle_hgt)
                            pos = i;
                    end
                    if (pos < idle_hgt)
                    begin
                        for (int i = pos; i + 1 < idle_hgt; i++)
                            idle_stk[i] = idle_stk[i + 1];
                        idle_hgt--;
                    end
                    listed[wid] = 1'b0;
                end
                owe_outcome(make_outcome(1'b0, 1'b0, 1'b0, '0, 1'b1));
            end
            ACT_NEW_TASK:
            begin
                // A spinner will pick the task up; only wake someone if nobody spins.
                if (idle_hgt > 0 && spin_cnt == 0)
                begin
                    idle_hgt--;
                    w = idle_stk[idle_hgt];
                    listed[w] = 1'b0;
                    owe_outcome(make_outcome(1'b0, 1'b0, 1'b1, w, 1'b1));
                end
                else
                begin
                    owe_outcome(make_outcome(1'b0, 1'b0, 1'b0, '0, 1'b1));
                end
            end
            ACT_REQ_STOP:
            begin
                // Sticky flag, then every idle worker is woken newest first.
                stop_seen = 1'b1;
                if (idle_hgt == 0)
                begin
                    owe_outcome(make_outcome(1'b0, 1'b0, 1'b0, '0, 1'b1));
                end
                else
                begin
                    n = 0;
                    while (idle_hgt > 0 && n < 64)
                    begin
                        idle_hgt--;
                        w = idle_stk[idle_hgt];
                        listed[w] = 1'b0;
                        owe_outcome(make_outcome(1'b0, 1'b0, 1'b1, w,
                                                 idle_hgt == 0 || n == 63));
                        n++;
                    end
                end
            end
            default:
            begin
                owe_outcome(make_outcome(1'b0, 1'b0, 1'b0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Sender: presents the next pending event at the falling edge once the
    // previous beat was taken, with an optional gap after each beat.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    next_beat = beat_q.pop_front();
                    in_valid  <= 1'b1;
                    action    <= next_beat.act;
                    worker_id <= next_beat.wid;
                    in_gap    <= idle_enable ? idle_len() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure on the result channel.
    always @(negedge clk)
    begin
        if (!rst_n || !idle_enable)
        begin
            out_ready <= rst_n;
            out_stall <= 0;
        end
        else if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= idle_len();
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: checks result beats against the oldest expectation, feeds
    // accepted input beats to the shadow model, and runs the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {spin_granted, last_spinner, woken_valid, woken_worker, stop_flag,
                       spinning_count, idle_count, last};
                if (outcome_due_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    outcome_t exp_o;
                    exp_o = outcome_due_q.pop_front();
                    check_field("spin_granted", exp_o.granted, got.granted);
                    check_field("last_spinner", exp_o.last_spin, got.last_spin);
                    check_field("woken_valid", exp_o.wvalid, got.wvalid);
                    check_field("woken_worker", exp_o.wworker, got.wworker);
                    check_field("stop_flag", exp_o.stop, got.stop);
                    check_field("spinning_count", exp_o.spin, got.spin);
                    check_field("idle_count", exp_o.idle, got.idle);
                    check_field("last", exp_o.last, got.last);
                end
            end
            if (in_valid && in_ready)
                apply_sched_event(action, worker_id);
            in_taken <= in_valid && in_ready;

            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic queue_beat(input logic [ACT_W-1:0] act, input logic [WID_W-1:0] wid);
        sched_beat_t b;
        b.act = act;
        b.wid = wid;
        beat_q = {beat_q, b};
    endtask

    // Waits until every event is sent and every owed result beat has arrived. The
    // check runs at the rising edge, where the sender's signals are settled.
    task automatic drain_and_settle();
        @(posedge clk);
        while (beat_q.size() != 0 || in_valid || outcome_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes worker_count while the block is idle, then reads it back.
    task automatic set_worker_count(input int value);
        drain_and_settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WCNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        wcnt_shadow = value & 127;
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", wcnt_shadow, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A random event; half of the worker numbers come from a small pool so
    // that listed and unlisted workers collide often.
    function automatic sched_beat_t random_beat();
        sched_beat_t b;
        int r;
        r     = $urandom_range(0, 99);
        b.wid = $urandom_range(0, 1) ? WID_W'($urandom_range(0, 7))
                                     : WID_W'($urandom_range(0, 63));
        if (r < 14)
            b.act = ACT_START_SPIN;
        else if (r < 28)
            b.act = ACT_STOP_SPIN;
        else if (r < 55)
            b.act = ACT_STEP_DOWN;
        else if (r < 75)
            b.act = ACT_BECOME_ACTIVE;
        else if (r < 89)
            b.act = ACT_NEW_TASK;
        else if (r < 94)
            b.act = ACT_REQ_STOP;
        else
            b.act = $urandom_range(0, 1) ? ACT_UNUSED_7 : ACT_UNUSED_6;
        return b;
    endfunction

    // One random phase: single events mixed with runs of spin requests and
    // runs of workers going to sleep, which build up deep state. Runs are
    // cut short so that the phase sends exactly n_items events.
    task automatic random_phase(input int wc, input int n_items, input bit idle_on);
        int          count;
        int          r;
        int          k;
        sched_beat_t b;
        set_worker_count(wc);
        idle_enable = idle_on;
        count = 0;
        while (count < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                k = $urandom_range(4, 34);
                if (k > n_items - count)
                    k = n_items - count;
                repeat (k) queue_beat(ACT_START_SPIN, WID_W'($urandom_range(0, 63)));
                count += k;
            end
            else if (r < 16)
            begin
                k = $urandom_range(3, 16);
                if (k > n_items - count)
                    k = n_items - count;
                repeat (k) queue_beat(ACT_STEP_DOWN, WID_W'($urandom_range(0, 63)));
                count += k;
            end
            else
            begin
                b = random_beat();
                queue_beat(b.act, b.wid);
                count++;
            end
        end
    endtask

    initial
    begin
        int perm[MAX_WORKERS];
        int picked[3];
        int j;
        int tmp;

        wcnt_shadow = int'(WORKER_COUNT_RST);
        spin_cnt    = 0;
        idle_hgt    = 0;
        stop_seen   = 1'b0;
        for (int i = 0; i < MAX_WORKERS; i++)
        begin
            listed[i]   = 1'b0;
            idle_stk[i] = '0;
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: each action, its corner cases and the stop path.
        set_worker_count(64);
        queue_beat(ACT_STOP_SPIN, 6'd0);          // nobody spins yet
        queue_beat(ACT_START_SPIN, 6'd0);
        queue_beat(ACT_STOP_SPIN, 6'd0);          // the last spinner leaves
        queue_beat(ACT_STEP_DOWN, 6'd0);
        queue_beat(ACT_STEP_DOWN, 6'd63);
        queue_beat(ACT_STEP_DOWN, 6'd0);          // already listed, ignored
        queue_beat(ACT_BECOME_ACTIVE, 6'd5);      // not listed, ignored
        queue_beat(ACT_START_SPIN, 6'd0);
        queue_beat(ACT_NEW_TASK, 6'd0);           // a spinner takes it, nobody woken
        queue_beat(ACT_STOP_SPIN, 6'd0);
        queue_beat(ACT_NEW_TASK, 6'd0);           // wakes the newest idle worker
        queue_beat(ACT_STEP_DOWN, 6'd42);
        queue_beat(ACT_STEP_DOWN, 6'd21);
        queue_beat(ACT_BECOME_ACTIVE, 6'd0);      // bottom entry, gap closes
        queue_beat(ACT_UNUSED_6, 6'd0);
        queue_beat(ACT_UNUSED_7, 6'd63);
        queue_beat(ACT_REQ_STOP, 6'd0);           // wakes two, newest first
        queue_beat(ACT_REQ_STOP, 6'd0);           // empty stack, one status beat
        queue_beat(ACT_NEW_TASK, 6'd0);           // no idle worker left

        // Zero and tiny worker counts around the spin limit.
        set_worker_count(0);
        queue_beat(ACT_START_SPIN, 6'd0);
        queue_beat(ACT_STOP_SPIN, 6'd0);
        set_worker_count(1);
        queue_beat(ACT_START_SPIN, 6'd0);
        set_worker_count(2);
        queue_beat(ACT_START_SPIN, 6'd0);
        queue_beat(ACT_START_SPIN, 6'd0);
        queue_beat(ACT_STOP_SPIN, 6'd0);

        // Random part over several spin limits, one phase with no idling.
        random_phase(127, 15, 1'b1);
        random_phase(3, 15, 1'b1);
        random_phase(64, 15, 1'b0);
        random_phase(10, 15, 1'b1);
        random_phase($urandom_range(1, 64), 15, 1'b1);

        // Every worker goes to sleep in random order, so all 64 are listed.
        // A few leave the stack and come back on top, and then a single
        // stop request wakes all 64 of them.
        set_worker_count(64);
        idle_enable = 1'b1;
        for (int i = 0; i < MAX_WORKERS; i++)
            perm[i] = i;
        for (int i = MAX_WORKERS - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < MAX_WORKERS; i++)
            queue_beat(ACT_STEP_DOWN, WID_W'(perm[i]));
        for (int i = 0; i < 3; i++)
        begin
            picked[i] = perm[$urandom_range(0, 63)];
            queue_beat(ACT_BECOME_ACTIVE, WID_W'(picked[i]));
        end
        for (int i = 0; i < 3; i++)
            queue_beat(ACT_STEP_DOWN, WID_W'(picked[i]));
        queue_beat(ACT_REQ_STOP, 6'd0);

        drain_and_settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/wwc_pkg.sv
design/wwc_ram.sv
design/wwc_ctrl.sv
design/wwc_dp.sv
design/worker_wake_coordinator.sv
test/tb_worker_wake_coordinator.sv
